[design/hnq_pkg.sv]
`default_nettype none
package hnq_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] CFG_MAP_LENGTH = 3'd0;
    localparam logic [2:0] CFG_MAP_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_SIZE_X     = 3'd2;
    localparam logic [2:0] CFG_SIZE_Y     = 3'd3;
    localparam logic [2:0] CFG_SIZE_Z     = 3'd4;

    typedef struct packed {
        logic               operation;
        logic [13:0]        entry_index;
        logic [15:0]        height_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_z;
    } t_req;

    typedef struct packed {
        logic               in_bounds;
        logic signed [31:0] height;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_res;

endpackage
`default_nettype wire

[design/heightmap_height_and_normal_query_unit.sv]
`default_nettype none
// Height and normal query over a loaded heightmap. Requests are taken every cycle
// (busy stays low); a write request updates the store and gives no result, a
// query gives one result, strobed for a single cycle. With CW defined as
// clog2(max(MAX_LENGTH, MAX_WIDTH)), the pipeline holds the bit-per-stage grid
// divider (CW+16 stages), the 31-stage square root and the 16-stage normal divider.
// Results come in request order and must be taken as they appear. The user must
// see that configuration is written only while no query is in flight; the block
// does not enforce it. The store is read and written in request order at one stage.
module heightmap_height_and_normal_query_unit #(
    parameter int MAX_LENGTH = 128,
    parameter int MAX_WIDTH  = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  hnq_pkg::t_req  i_req,
    output logic           o_res_strobe,
    output hnq_pkg::t_res  o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import hnq_pkg::*;

    localparam int MAXN  = (MAX_LENGTH > MAX_WIDTH) ? MAX_LENGTH : MAX_WIDTH;
    localparam int CW    = $clog2(MAXN);
    localparam int GW    = CW + 16;
    localparam int GDW   = GW + 32;
    localparam int CMPW  = (CW > 8) ? CW + 1 : 9;
    localparam int DEPTH = MAX_LENGTH * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SL    = 31;
    localparam int NQW   = 16;
    localparam int NDW   = 31;
    localparam int NNW   = NDW + NQW;

    typedef struct packed {
        logic        op;
        logic [13:0] idx;
        logic [15:0] hgt;
        logic        ok;
    } t_sb_a;

    typedef struct packed {
        logic        ok;
        logic        ax_neg;
        logic [15:0] ax_mag;
        logic        cz_neg;
        logic [15:0] cz_mag;
        logic [31:0] interp;
    } t_sb_g;

    typedef struct packed {
        logic        ok;
        logic        ax_neg;
        logic        cz_neg;
        logic [31:0] hq;
    } t_sb_j;

    function automatic logic [15:0] norm_fix(input logic neg, input logic [NQW-1:0] q);
        logic [15:0] m;
        m = (q > NQW'(16384)) ? 16'd16384 : 16'(q);
        return neg ? (16'd0 - m) : m;
    endfunction

    function automatic logic [31:0] round_sat(input logic [63:0] prod);
        logic [64:0] t;
        logic [40:0] h;
        t = {1'b0, prod} + 65'd8388608;
        h = t[64:24];
        return (h > 41'h7FFFFFFF) ? 32'h7FFFFFFF : h[31:0];
    endfunction

    // ---------------- configuration
    logic [7:0]  r_len;
    logic [7:0]  r_wid;
    logic [31:0] r_sx;
    logic [31:0] r_sy;
    logic [31:0] r_sz;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 8'd2;
            r_wid <= 8'd2;
            r_sx  <= 32'h0001_0000;
            r_sy  <= 32'h0001_0000;
            r_sz  <= 32'h0001_0000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_LENGTH: r_len <= i_cfg_data[7:0];
                CFG_MAP_WIDTH:  r_wid <= i_cfg_data[7:0];
                CFG_SIZE_X:     r_sx  <= i_cfg_data;
                CFG_SIZE_Y:     r_sy  <= i_cfg_data;
                CFG_SIZE_Z:     r_sz  <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // ---------------- stage A: bounds check and numerator product
    logic        acc;
    logic        cfg_ok;
    logic        ok_x;
    logic        ok_z;
    logic        r_a_vld;
    t_sb_a       r_a_sb;
    logic [38:0] r_a_numx;
    logic [38:0] r_a_numz;

    assign acc    = start && !busy;
    assign cfg_ok = (r_len >= 8'd2) && (32'(r_len) <= 32'(MAX_LENGTH))
                 && (r_wid >= 8'd2) && (32'(r_wid) <= 32'(MAX_WIDTH))
                 && (r_sx != '0) && (r_sz != '0);
    assign ok_x   = !i_req.query_x[31] && (32'(i_req.query_x) <= r_sx);
    assign ok_z   = !i_req.query_z[31] && (32'(i_req.query_z) <= r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sb.op  <= i_req.operation;
        r_a_sb.idx <= i_req.entry_index;
        r_a_sb.hgt <= i_req.height_value;
        r_a_sb.ok  <= cfg_ok && ok_x && ok_z;
        r_a_numx   <= i_req.query_x[30:0] * (r_len - 8'd1);
        r_a_numz   <= i_req.query_z[30:0] * (r_wid - 8'd1);
    end

    // ---------------- grid dividers
    logic [GW-1:0] q_x;
    logic [GW-1:0] q_z;

    hnq_div #(.DW(32), .QW(GW)) u_div_x (
        .i_clk (i_clk),
        .i_num (GDW'({r_a_numx, 16'd0})),
        .i_den (r_sx),
        .o_quo (q_x)
    );

    hnq_div #(.DW(32), .QW(GW)) u_div_z (
        .i_clk (i_clk),
        .i_num (GDW'({r_a_numz, 16'd0})),
        .i_den (r_sz),
        .o_quo (q_z)
    );

    logic [GW-1:0] r_ad_vld;
    t_sb_a         r_ad_sb [GW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad_vld <= '0;
        end else begin
            r_ad_vld <= {r_ad_vld[GW-2:0], r_a_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ad_sb[0] <= r_a_sb;
        for (int i = 1; i < GW; i++) begin
            r_ad_sb[i] <= r_ad_sb[i-1];
        end
    end

    // ---------------- stage B: cell and fraction, far edge clamp
    logic [CW-1:0] cell_x;
    logic [CW-1:0] cell_z;
    logic [16:0]   frac_x;
    logic [16:0]   frac_z;
    logic          r_b_vld;
    t_sb_a         r_b_sb;
    logic [CW-1:0] r_b_ix;
    logic [CW-1:0] r_b_iz;
    logic [16:0]   r_b_fx;
    logic [16:0]   r_b_fz;

    always_comb begin
        cell_x = q_x[GW-1:16];
        frac_x = {1'b0, q_x[15:0]};
        if (CMPW'(cell_x) + CMPW'(1) >= CMPW'(r_len)) begin
            cell_x = CW'(r_len - 8'd2);
            frac_x = 17'h10000;
        end
        cell_z = q_z[GW-1:16];
        frac_z = {1'b0, q_z[15:0]};
        if (CMPW'(cell_z) + CMPW'(1) >= CMPW'(r_wid)) begin
            cell_z = CW'(r_wid - 8'd2);
            frac_z = 17'h10000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_ad_vld[GW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sb <= r_ad_sb[GW-1];
        r_b_ix <= cell_x;
        r_b_iz <= cell_z;
        r_b_fx <= frac_x;
        r_b_fz <= frac_z;
    end

    // ---------------- stage C: store addresses, store access
    logic          r_c_vld;
    t_sb_a         r_c_sb;
    logic [AW-1:0] r_c_row0;
    logic [AW-1:0] r_c_row1;
    logic [16:0]   r_c_fx;
    logic [16:0]   r_c_fz;
    logic [AW-1:0] row0;

    assign row0 = AW'(AW'(r_b_iz) * AW'(r_len)) + AW'(r_b_ix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sb   <= r_b_sb;
        r_c_row0 <= row0;
        r_c_row1 <= row0 + AW'(r_len);
        r_c_fx   <= r_b_fx;
        r_c_fz   <= r_b_fz;
    end

    logic        we;
    logic [15:0] h1;
    logic [15:0] h3;
    logic [15:0] h0;
    logic [15:0] h2;

    // writes land at the same stage queries read, keeping request order
    assign we = r_c_vld && (r_c_sb.op == OP_WRITE)
             && ({18'd0, r_c_sb.idx} < 32'(DEPTH));

    hnq_ram #(.DEPTH(DEPTH)) u_ram_lo (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (AW'(r_c_sb.idx)),
        .i_wdata   (r_c_sb.hgt),
        .i_raddr_a (r_c_row0),
        .i_raddr_b (r_c_row0 + AW'(1)),
        .o_rdata_a (h1),
        .o_rdata_b (h3)
    );

    hnq_ram #(.DEPTH(DEPTH)) u_ram_hi (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (AW'(r_c_sb.idx)),
        .i_wdata   (r_c_sb.hgt),
        .i_raddr_a (r_c_row1),
        .i_raddr_b (r_c_row1 + AW'(1)),
        .o_rdata_a (h0),
        .o_rdata_b (h2)
    );

    // ---------------- stage D: store data arrives
    logic        r_d_vld;
    logic        r_d_ok;
    logic [16:0] r_d_fx;
    logic [16:0] r_d_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld && (r_c_sb.op == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_ok <= r_c_sb.ok;
        r_d_fx <= r_c_fx;
        r_d_fz <= r_c_fz;
    end

    // ---------------- stage E: triangle select
    logic signed [16:0] s0;
    logic signed [16:0] s1;
    logic signed [16:0] s2;
    logic signed [16:0] s3;
    logic signed [16:0] ax;
    logic signed [16:0] cz;
    logic               r_e_vld;
    logic               r_e_ok;
    logic [15:0]        r_e_base;
    logic [16:0]        r_e_wa;
    logic [16:0]        r_e_wb;
    logic signed [16:0] r_e_da;
    logic signed [16:0] r_e_db;
    logic               r_e_ax_neg;
    logic [15:0]        r_e_ax_mag;
    logic               r_e_cz_neg;
    logic [15:0]        r_e_cz_mag;

    assign s0 = $signed({1'b0, h0});
    assign s1 = $signed({1'b0, h1});
    assign s2 = $signed({1'b0, h2});
    assign s3 = $signed({1'b0, h3});
    assign ax = (r_d_fz > r_d_fx) ? s0 - s2 : s1 - s3;
    assign cz = (r_d_fz > r_d_fx) ? s1 - s0 : s3 - s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ok <= r_d_ok;
        if (r_d_fz > r_d_fx) begin
            r_e_base <= h0;
            r_e_wa   <= r_d_fx;
            r_e_da   <= s2 - s0;
            r_e_wb   <= 17'h10000 - r_d_fz;
            r_e_db   <= s1 - s0;
        end else begin
            r_e_base <= h3;
            r_e_wa   <= 17'h10000 - r_d_fx;
            r_e_da   <= s1 - s3;
            r_e_wb   <= r_d_fz;
            r_e_db   <= s2 - s3;
        end
        r_e_ax_neg <= ax[16];
        r_e_ax_mag <= ax[16] ? 16'(-ax) : ax[15:0];
        r_e_cz_neg <= cz[16];
        r_e_cz_mag <= cz[16] ? 16'(-cz) : cz[15:0];
    end

    // ---------------- stage F: products
    logic               r_f_vld;
    logic               r_f_ok;
    logic [15:0]        r_f_base;
    logic signed [34:0] r_f_pa;
    logic signed [34:0] r_f_pb;
    logic [31:0]        r_f_ax2;
    logic [31:0]        r_f_cz2;
    logic               r_f_ax_neg;
    logic [15:0]        r_f_ax_mag;
    logic               r_f_cz_neg;
    logic [15:0]        r_f_cz_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_ok     <= r_e_ok;
        r_f_base   <= r_e_base;
        r_f_pa     <= $signed({1'b0, r_e_wa}) * r_e_da;
        r_f_pb     <= $signed({1'b0, r_e_wb}) * r_e_db;
        r_f_ax2    <= r_e_ax_mag * r_e_ax_mag;
        r_f_cz2    <= r_e_cz_mag * r_e_cz_mag;
        r_f_ax_neg <= r_e_ax_neg;
        r_f_ax_mag <= r_e_ax_mag;
        r_f_cz_neg <= r_e_cz_neg;
        r_f_cz_mag <= r_e_cz_mag;
    end

    // ---------------- stage G: interpolated height, squared length
    logic signed [36:0] isum;
    logic               r_g_vld;
    t_sb_g              r_g_sb;
    logic [33:0]        r_g_s;

    assign isum = $signed({5'd0, r_f_base, 16'd0})
                + $signed({{2{r_f_pa[34]}}, r_f_pa})
                + $signed({{2{r_f_pb[34]}}, r_f_pb});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_sb.ok     <= r_f_ok;
        r_g_sb.ax_neg <= r_f_ax_neg;
        r_g_sb.ax_mag <= r_f_ax_mag;
        r_g_sb.cz_neg <= r_f_cz_neg;
        r_g_sb.cz_mag <= r_f_cz_mag;
        r_g_sb.interp <= isum[36] ? 32'd0 : isum[31:0];
        r_g_s         <= 34'(r_f_ax2) + 34'(r_f_cz2) + 34'd65536;
    end

    // ---------------- square root, two result bits per stage pair
    logic [61:0] r_sq_v [SL];
    logic [62:0] r_sq_r [SL];

    for (genvar k = 0; k < SL; k++) begin : g_sqrt
        logic [61:0] v_in;
        logic [62:0] r_in;
        logic [62:0] bit_k;
        logic [62:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign v_in = {r_g_s, 28'd0};
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_sq_v[k-1];
            assign r_in = r_sq_r[k-1];
        end

        assign bit_k = 63'd1 << (2 * (SL - 1 - k));
        assign trial = r_in + bit_k;
        assign ge    = {1'b0, v_in} >= trial;

        always_ff @(posedge i_clk) begin
            r_sq_v[k] <= ge ? v_in - trial[61:0] : v_in;
            r_sq_r[k] <= ge ? (r_in >> 1) + bit_k : (r_in >> 1);
        end
    end

    logic [SL-1:0] r_gd_vld;
    t_sb_g         r_gd_sb [SL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gd_vld <= '0;
        end else begin
            r_gd_vld <= {r_gd_vld[SL-2:0], r_g_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_gd_sb[0] <= r_g_sb;
        for (int i = 1; i < SL; i++) begin
            r_gd_sb[i] <= r_gd_sb[i-1];
        end
    end

    // ---------------- stage J: normal numerators, height scale
    logic [NDW-1:0] root;
    logic           r_j_vld;
    logic           r_j_ok;
    logic           r_j_ax_neg;
    logic           r_j_cz_neg;
    logic [63:0]    r_j_prod;
    logic [NDW-1:0] r_j_root;
    logic [NNW-1:0] r_j_numx;
    logic [NNW-1:0] r_j_numy;
    logic [NNW-1:0] r_j_numz;

    assign root = r_sq_r[SL-1][NDW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else begin
            r_j_vld <= r_gd_vld[SL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_ok     <= r_gd_sb[SL-1].ok;
        r_j_ax_neg <= r_gd_sb[SL-1].ax_neg;
        r_j_cz_neg <= r_gd_sb[SL-1].cz_neg;
        r_j_prod   <= r_gd_sb[SL-1].interp * r_sy;
        r_j_root   <= root;
        r_j_numx   <= NNW'({r_gd_sb[SL-1].ax_mag, 28'd0}) + NNW'(root >> 1);
        r_j_numy   <= NNW'({16'd256, 28'd0}) + NNW'(root >> 1);
        r_j_numz   <= NNW'({r_gd_sb[SL-1].cz_mag, 28'd0}) + NNW'(root >> 1);
    end

    // ---------------- normal dividers
    logic [NQW-1:0] nq_x;
    logic [NQW-1:0] nq_y;
    logic [NQW-1:0] nq_z;

    hnq_div #(.DW(NDW), .QW(NQW)) u_ndiv_x (
        .i_clk (i_clk),
        .i_num (r_j_numx),
        .i_den (r_j_root),
        .o_quo (nq_x)
    );

    hnq_div #(.DW(NDW), .QW(NQW)) u_ndiv_y (
        .i_clk (i_clk),
        .i_num (r_j_numy),
        .i_den (r_j_root),
        .o_quo (nq_y)
    );

    hnq_div #(.DW(NDW), .QW(NQW)) u_ndiv_z (
        .i_clk (i_clk),
        .i_num (r_j_numz),
        .i_den (r_j_root),
        .o_quo (nq_z)
    );

    logic [NQW-1:0] r_jd_vld;
    t_sb_j          r_jd_sb [NQW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jd_vld <= '0;
        end else begin
            r_jd_vld <= {r_jd_vld[NQW-2:0], r_j_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_jd_sb[0].ok     <= r_j_ok;
        r_jd_sb[0].ax_neg <= r_j_ax_neg;
        r_jd_sb[0].cz_neg <= r_j_cz_neg;
        r_jd_sb[0].hq     <= round_sat(r_j_prod);
        for (int i = 1; i < NQW; i++) begin
            r_jd_sb[i] <= r_jd_sb[i-1];
        end
    end

    // ---------------- stage K: result register
    logic r_res_strobe;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= r_jd_vld[NQW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_jd_sb[NQW-1].ok) begin
            r_res.in_bounds <= 1'b1;
            r_res.height    <= r_jd_sb[NQW-1].hq;
            r_res.normal_x  <= norm_fix(r_jd_sb[NQW-1].ax_neg, nq_x);
            r_res.normal_y  <= norm_fix(1'b0, nq_y);
            r_res.normal_z  <= norm_fix(r_jd_sb[NQW-1].cz_neg, nq_z);
        end else begin
            r_res <= '0;
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

endmodule
`default_nettype wire

[design/hnq_div.sv]
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees i_num < i_den * 2^QW.
module hnq_div #(
    parameter int DW = 32,
    parameter int QW = 23
) (
    input  logic             i_clk,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_quo
);
    localparam int W = DW + QW;

    logic [W-1:0]  r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [W-1:0]  trial;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign den_in = r_den[i-1];
            assign quo_in = r_quo[i-1];
        end

        assign trial = W'(den_in) << (QW - 1 - i);
        assign ge    = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[i] <= ge ? rem_in - trial : rem_in;
            r_den[i] <= den_in;
            r_quo[i] <= quo_in | (QW'(ge) << (QW - 1 - i));
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule
`default_nettype wire

[design/hnq_ram.sv]
`default_nettype none
module hnq_ram #(
    parameter int   DEPTH = 16384,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [15:0]   o_rdata_a,
    output logic [15:0]   o_rdata_b
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata_a;
    logic [15:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

[test/tb_heightmap_height_and_normal_query_unit.sv]
`default_nettype none
module tb_heightmap_height_and_normal_query_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import hnq_pkg::*;

    localparam int DEPTH   = 128 * 128;
    localparam int LATENCY = 78;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_res_strobe;
    t_res        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    heightmap_height_and_normal_query_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_strobe(o_res_strobe), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [15:0] heights [DEPTH];
    logic [31:0] m_len, m_wid, m_sx, m_sy, m_sz;

    t_req   pending_reqs[$];
    t_res   expected_results[$];
    int     n_errors = 0;
    bit     stall_free = 1'b0;
    logic   taken_q = 1'b0;

    // cfg write (idle only); mirror in predictor
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAP_LENGTH: m_len = {24'd0, val[7:0]};
            CFG_MAP_WIDTH:  m_wid = {24'd0, val[7:0]};
            CFG_SIZE_X:     m_sx = val;
            CFG_SIZE_Y:     m_sy = val;
            CFG_SIZE_Z:     m_sz = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_comp(input longint v, input logic [63:0] r);
        logic [63:0] mag, q;
        mag = (v < 0) ? -v : v;
        q = ((mag << 28) + (r >> 1)) / r;
        if (q > 16384) q = 16384;
        if (v < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic bit grid_split(input logic [31:0] raw, input logic [31:0] sz,
                                      input logic [31:0] n, output int seg, output int frac);
        logic [63:0] g;
        seg = 0;
        frac = 0;
        if (raw[31] || raw > sz) return 1'b0;
        g = ((64'(raw) * 64'(n - 1)) << 16) / 64'(sz);
        seg = int'(g >> 16);
        frac = int'(g & 64'hFFFF);
        if (seg >= n - 1) begin
            seg = n - 2;
            frac = 65536;
        end
        return 1'b1;
    endfunction

    function automatic longint sample(input int x, input int z);
        int idx;
        idx = x + z * m_len;
        return (idx >= DEPTH) ? 0 : longint'(heights[idx]);
    endfunction

    function automatic t_res surface_query(input t_req q);
        t_res res;
        int ix, iz, fx, fz;
        longint h0, h1, h2, h3, interp, ax, cz;
        logic [63:0] hq, s, r;
        res = '0;
        if (m_len < 2 || m_len > 128 || m_wid < 2 || m_wid > 128) return res;
        if (m_sx == 0 || m_sz == 0) return res;
        if (!grid_split(q.query_x, m_sx, m_len, ix, fx)) return res;
        if (!grid_split(q.query_z, m_sz, m_wid, iz, fz)) return res;
        h0 = sample(ix, iz + 1);
        h1 = sample(ix, iz);
        h2 = sample(ix + 1, iz + 1);
        h3 = sample(ix + 1, iz);
        if (fz > fx) begin
            interp = h0 * 65536 + longint'(fx) * (h2 - h0) + longint'(65536 - fz) * (h1 - h0);
            ax = h0 - h2;
            cz = h1 - h0;
        end else begin
            interp = h3 * 65536 + longint'(65536 - fx) * (h1 - h3) + longint'(fz) * (h2 - h3);
            ax = h1 - h3;
            cz = h3 - h2;
        end
        if (interp < 0) interp = 0;
        // interp < 2^32, size_y < 2^32: product fits 64 bits unsigned
        hq = (64'(interp) * 64'(m_sy) + (64'd1 << 23)) >> 24;
        if (hq > 64'h7FFFFFFF) hq = 64'h7FFFFFFF;
        s = 64'(ax * ax) + 65536 + 64'(cz * cz);
        r = isqrt(s << 28);
        res.in_bounds = 1'b1;
        res.height    = hq[31:0];
        res.normal_x  = unit_comp(ax, r);
        res.normal_y  = unit_comp(256, r);
        res.normal_z  = unit_comp(cz, r);
        return res;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!start || taken_q) begin
                if (pending_reqs.size() > 0 && (stall_free || $urandom_range(99) >= 37)) begin
                    i_req <= pending_reqs.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // acceptance sampled at rising edge; predictor runs in request order
    always @(posedge i_clk) begin
        taken_q <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            if (i_req.operation == OP_WRITE) begin
                if (i_req.entry_index < DEPTH) heights[i_req.entry_index] = i_req.height_value;
            end else begin
                expected_results.push_back(surface_query(i_req));
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_res_strobe) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result %p", o_res);
                n_errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_res.in_bounds !== e.in_bounds) begin
                    $error("in_bounds exp %0d got %0d", e.in_bounds, o_res.in_bounds);
                    n_errors++;
                end
                if (o_res.height !== e.height) begin
                    $error("height exp %0d got %0d", e.height, o_res.height);
                    n_errors++;
                end
                if (o_res.normal_x !== e.normal_x) begin
                    $error("normal_x exp %0d got %0d", e.normal_x, o_res.normal_x);
                    n_errors++;
                end
                if (o_res.normal_y !== e.normal_y) begin
                    $error("normal_y exp %0d got %0d", e.normal_y, o_res.normal_y);
                    n_errors++;
                end
                if (o_res.normal_z !== e.normal_z) begin
                    $error("normal_z exp %0d got %0d", e.normal_z, o_res.normal_z);
                    n_errors++;
                end
            end
        end
    end

    function automatic t_req mk_write(input int idx, input logic [15:0] h);
        t_req q;
        q = '0;
        q.operation    = OP_WRITE;
        q.entry_index  = idx[13:0];
        q.height_value = h;
        q.query_x      = $urandom;
        q.query_z      = $urandom;
        return q;
    endfunction

    function automatic t_req mk_query(input logic [31:0] x, input logic [31:0] z);
        t_req q;
        q = '0;
        q.operation    = OP_QUERY;
        q.entry_index  = $urandom;
        q.height_value = $urandom;
        q.query_x      = x;
        q.query_z      = z;
        return q;
    endfunction

    // coordinate in 0..size, with edges and off-terrain points now and then
    function automatic logic [31:0] pick_coord(input logic [31:0] sz);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return sz;
            2: return sz + 1;
            3: return 32'h8000_0000 | $urandom;
            4: return $urandom;
            default: return 32'($urandom_range(sz[31:0] & 32'h7FFF_FFFF));
        endcase
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // fill every entry of the map in use so no unwritten entry is read;
    // with a bad map shape no entry is read at all
    task automatic load_map(input int len, input int wid, input bit extreme);
        if (len < 2 || len > 128 || wid < 2 || wid > 128) return;
        for (int i = 0; i < len * wid; i++)
            pending_reqs.push_back(mk_write(i, extreme ? (($urandom_range(1)) ? 16'hFFFF : 16'h0)
                                                       : 16'($urandom)));
    endtask

    task automatic run_phase(input int len, input int wid, input logic [31:0] sx,
                             input logic [31:0] sy, input logic [31:0] sz, input int n_q,
                             input bit extreme);
        write_reg(CFG_MAP_LENGTH, 32'(len));
        write_reg(CFG_MAP_WIDTH, 32'(wid));
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        load_map(len, wid, extreme);
        for (int i = 0; i < n_q; i++) begin
            if ($urandom_range(9) == 0)
                pending_reqs.push_back(mk_write($urandom_range(len * wid - 1), $urandom));
            else
                pending_reqs.push_back(mk_query(pick_coord(sx), pick_coord(sz)));
        end
        drain();
    endtask

    initial begin
        m_len = 2; m_wid = 2; m_sx = 65536; m_sy = 65536; m_sz = 65536;
        foreach (heights[i]) heights[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default config, corners, far edge, both triangles, off terrain
        pending_reqs.push_back(mk_write(0, 16'h0000));
        pending_reqs.push_back(mk_write(1, 16'hFFFF));
        pending_reqs.push_back(mk_write(2, 16'h1234));
        pending_reqs.push_back(mk_write(3, 16'hFFFF));
        pending_reqs.push_back(mk_write(16383, 16'hAAAA));  // beyond map in use
        pending_reqs.push_back(mk_query(32'h0, 32'h0));
        pending_reqs.push_back(mk_query(32'h10000, 32'h10000));
        pending_reqs.push_back(mk_query(32'h4000, 32'hC000));
        pending_reqs.push_back(mk_query(32'hC000, 32'h4000));
        pending_reqs.push_back(mk_query(32'h8000, 32'h8000));
        pending_reqs.push_back(mk_query(32'h10001, 32'h0));
        pending_reqs.push_back(mk_query(32'h0, 32'h10001));
        pending_reqs.push_back(mk_query(32'h8000_0000, 32'h0));
        pending_reqs.push_back(mk_query(32'h0, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_query(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        drain();

        // bad configurations: every query is off terrain
        run_phase(1, 2, 32'h10000, 32'h10000, 32'h10000, 8, 1'b0);
        run_phase(2, 255, 32'h10000, 32'h10000, 32'h10000, 8, 1'b0);
        run_phase(2, 2, 32'h0, 32'h10000, 32'h0, 8, 1'b0);
        run_phase(129, 2, 32'h10000, 32'h10000, 32'h10000, 8, 1'b0);
        // extremes of size and height scaling
        run_phase(2, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30, 1'b1);
        run_phase(3, 2, 32'h1, 32'h0, 32'h1, 20, 1'b1);
        run_phase(128, 2, 32'h0080_0000, 32'h0001_0000, 32'h7FFF_FFFF, 16, 1'b0);
        run_phase(2, 9, 32'h7FFF_FFFF, 32'h0100_0000, 32'h0040_0000, 20, 1'b0);

        // random, long stretch first without idling
        stall_free = 1'b1;
        run_phase(5, 7, 32'h0005_0000, 32'h0003_8000, 32'h0002_0000, 80, 1'b0);
        stall_free = 1'b0;
        run_phase(4, 6, 32'($urandom), 32'($urandom), 32'($urandom) | 1, 40, 1'b0);
        run_phase(3, 4, 32'h0010_0000, 32'h0000_4000, 32'h0010_0000, 20, 1'b1);

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(12ns * 400000);
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
